FILE: hw/rtl/hash_message_padder_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the message padder
// Concurrent check wrappers, compiled out when ASSERT_OFF is defined.
// ----------------------------------------------------------------------------
`ifndef HASH_MESSAGE_PADDER_TOP_MACROS_SVH
`define HASH_MESSAGE_PADDER_TOP_MACROS_SVH

`ifndef ASSERT_OFF
// Check that cond holds at every clock edge outside reset.
`define HMP_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);
// Check that post holds in the cycle after pre.
`define HMP_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);
`else
`define HMP_ASSERT(lbl, cond, msg)
`define HMP_ASSERT_NEXT(lbl, pre, post, msg)
`endif

`endif

FILE: hw/rtl/hmp_pkg.sv
// ----------------------------------------------------------------------------
// Message padder package
// Codes and block geometry constants shared by the padder RTL.
// ----------------------------------------------------------------------------
package hmp_pkg;

  localparam int unsigned CountW = 61;
  localparam int unsigned WordW  = 64;

  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_END  = 1'b1;

  localparam logic MODE_512  = 1'b0;
  localparam logic MODE_1024 = 1'b1;

  // Byte offset at which the length field can no longer fit in the block.
  localparam logic [5:0] THR_512  = 6'd56;
  localparam logic [6:0] THR_1024 = 7'd112;

  // Last word index inside a block.
  localparam logic [3:0] LAST_WORD_512  = 4'd7;
  localparam logic [3:0] LAST_WORD_1024 = 4'd15;

  localparam logic [7:0] PAD_MARK = 8'h80;

endpackage

FILE: hw/rtl/hash_message_padder_top.sv
// ----------------------------------------------------------------------------
// Merkle-Damgard message padder, 512 and 1024 bit blocks
// Packs message bytes into 64-bit words and appends MD padding and length.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+-----------------------------------
//  in      | in        | in_valid / in_ready     | kind, message_byte
//  out     | out       | out_valid / out_ready   | data_word, block_end, message_end
//  cfg     | in        | cfg_valid / cfg_ready   | block_mode
//
//  A byte item is taken when in_ready is high; a word leaves every eighth byte.
//  An end item starts the padding sequencer, which then emits one word at a
//  time, 2 to 18 words, set by the single word counter that
//  walks the block.
//  The output register parts the sides: a new item is taken while the
//  previous word waits, as long as that word is leaving the same cycle.
//  rst is synchronous, active high; it clears count, gather and mode.
//  A stall on out holds the sequencer and the input side in place.
//
`include "hash_message_padder_top_macros.svh"

module hash_message_padder_top
  import hmp_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  // input items
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              kind,
  input  logic [7:0]        message_byte,
  // result items
  output logic              out_valid,
  input  logic              out_ready,
  output logic [WordW-1:0]  data_word,
  output logic              block_end,
  output logic              message_end,
  // configuration
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic              block_mode
);

  typedef enum logic {
    ST_IDLE,
    ST_PAD
  } state_t;

  state_t            state;
  logic              cur_mode;     // configured block mode
  logic              pad_mode;     // mode captured at the end item
  logic [CountW-1:0] byte_count;   // message bytes so far, mod 2^61
  logic [55:0]       pending;      // gathered bytes of the partial word
  logic [3:0]        word_idx;     // word position inside the current block
  logic              pad_extra;    // padding spills into one more block
  logic              first_word;   // next padding word carries the 0x80 mark

  logic [2:0]        fill;
  logic [CountW-1:0] count_next;
  logic [WordW-1:0]  byte_word;
  logic              byte_blk_end;
  logic [3:0]        start_idx;
  logic              start_extra;
  logic              blk_last;
  logic [WordW-1:0]  bit_len;
  logic [WordW-1:0]  pad_word;
  logic              out_free;
  logic              word_load;

  // Gather position follows the byte count: bytes per word is eight.
  assign fill       = byte_count[2:0];
  assign count_next = byte_count + CountW'(1);
  assign out_free   = !out_valid || out_ready;

  assign in_ready  = (state == ST_IDLE) && out_free;
  assign cfg_ready = 1'b1;

  // A new word enters the output register this cycle.
  assign word_load = ((state == ST_IDLE) && in_valid && in_ready && (kind == KIND_BYTE)
                      && (fill == 3'd7)) || ((state == ST_PAD) && out_free);

  // Insert the new byte at its lane of the partial word.
  assign byte_word = {8'h00, pending} | (WordW'(message_byte) << {fill, 3'b000});

  // A byte word closes a block when the new count hits a block boundary.
  assign byte_blk_end = (cur_mode == MODE_1024) ? (count_next[6:0] == 7'd0)
                                                : (count_next[5:0] == 6'd0);

  // Where padding starts, and whether the length still fits this block.
  always_comb begin
    if (cur_mode == MODE_1024) begin
      start_idx   = byte_count[6:3];
      start_extra = (byte_count[6:0] >= THR_1024);
    end else begin
      start_idx   = {1'b0, byte_count[5:3]};
      start_extra = (byte_count[5:0] >= THR_512);
    end
  end

  assign blk_last = (pad_mode == MODE_1024) ? (word_idx == LAST_WORD_1024)
                                            : (word_idx == LAST_WORD_512);

  // Length in bits, little-endian, wraps modulo 2^64.
  assign bit_len = {byte_count, 3'b000};

  // Shared word unit of the padding sequencer: mark word, zero word, or length.
  always_comb begin
    if (first_word) begin
      pad_word = {8'h00, pending} | (WordW'(PAD_MARK) << {fill, 3'b000});
    end else if (blk_last && !pad_extra) begin
      pad_word = bit_len;
    end else begin
      pad_word = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      out_valid   <= 1'b0;
      cur_mode    <= MODE_512;
      pad_mode    <= MODE_512;
      byte_count  <= '0;
      pending     <= '0;
      word_idx    <= '0;
      pad_extra   <= 1'b0;
      first_word  <= 1'b0;
      data_word   <= '0;
      block_end   <= 1'b0;
      message_end <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        cur_mode <= block_mode;
      end
      // Load a new word, or drop the current one once taken.
      if (word_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_valid && in_ready) begin
            if (kind == KIND_BYTE) begin
              byte_count <= count_next;
              if (fill == 3'd7) begin
                data_word   <= byte_word;
                block_end   <= byte_blk_end;
                message_end <= 1'b0;
                pending     <= '0;
              end else begin
                pending <= byte_word[55:0];
              end
            end else begin
              // End item: freeze geometry and start the padding walk.
              state      <= ST_PAD;
              pad_mode   <= cur_mode;
              word_idx   <= start_idx;
              pad_extra  <= start_extra;
              first_word <= 1'b1;
            end
          end
        end
        ST_PAD: begin
          if (out_free) begin
            data_word   <= pad_word;
            block_end   <= blk_last;
            message_end <= blk_last && !pad_extra;
            first_word  <= 1'b0;
            if (blk_last) begin
              word_idx <= '0;
              if (pad_extra) begin
                pad_extra <= 1'b0;
              end else begin
                // Length word sent: ready for the next message.
                state      <= ST_IDLE;
                byte_count <= '0;
                pending    <= '0;
              end
            end else begin
              word_idx <= word_idx + 4'd1;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // The length word always closes a block.
  `HMP_ASSERT(a_msg_end_closes_block, !(out_valid && message_end) || block_end, "message_end without block_end")
  // While the length word waits, the count has already restarted from zero.
  `HMP_ASSERT(a_count_cleared, !(out_valid && message_end) || (byte_count == '0), "byte count not cleared after message end")
  // An accepted end item starts the padding walk.
  `HMP_ASSERT_NEXT(a_end_starts_pad, in_valid && in_ready && (kind == KIND_END), (state == ST_PAD) && first_word, "end item did not start padding")

endmodule
